>>> hdl/trab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trab_pkg
// shared types and constants of the textured rectangle alpha blitter
// ----------------------------------------------------------------------------
package trab_pkg;

	localparam int MEM_DEPTH = 4096;
	localparam int ADDR_W    = 12;
	localparam int PIX_W     = 32;
	localparam int COORD_W   = 10;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 3;

	// request kinds
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_PIXEL = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RECT_X      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_Y      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_W      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_H      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TEX_START_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TEX_START_Y = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TEX_END_X   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_TEX_END_Y   = 3'd7;

	typedef struct packed {
		logic               req_type;
		logic [ADDR_W-1:0]  texel_index;
		logic [PIX_W-1:0]   texel_value;
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
		logic [PIX_W-1:0]   dst_pixel;
	} req_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic             covered;
	} rsp_t;

	// side data that travels beside the mapping pipeline
	typedef struct packed {
		logic              is_pix;
		logic              in_rect;
		logic [ADDR_W-1:0] index;
		logic [PIX_W-1:0]  value;
		logic [PIX_W-1:0]  dst;
	} side_t;

endpackage

>>> hdl/trab_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trab_stream_if
// valid/ready channel carrying one payload beat
// ----------------------------------------------------------------------------
interface trab_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/trab_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trab_ram
// generic simple dual port ram, registered read
// ----------------------------------------------------------------------------
module trab_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

>>> hdl/trab_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trab_axis
// nearest neighbor texel coordinate for one axis, pipelined divider
// ----------------------------------------------------------------------------
module trab_axis #(
	parameter int SIZE = 64
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [trab_pkg::COORD_W-1:0]  off,
	input  logic [6:0]                    start,
	input  logic [6:0]                    stop,
	input  logic [trab_pkg::CFG_W-1:0]    len,
	output logic [trab_pkg::COORD_W-1:0]  coord
);
	import trab_pkg::*;

	localparam int STAGES = 4;
	localparam int STEPS  = 4;
	localparam int NUM_W  = 16;
	localparam logic signed [18:0] MAX_C = 19'(SIZE - 1);

	logic signed [7:0] diff;
	logic [6:0]        mag;
	logic [16:0]       prod;

	logic [NUM_W-1:0]  dq_s  [STAGES+1];
	logic [CFG_W-1:0]  rem_s [STAGES+1];
	logic              neg_s [STAGES+1];

	// span and product
	always_comb begin
		diff = $signed({1'b0, stop}) - $signed({1'b0, start});
		mag  = diff[7] ? 7'(-diff) : diff[6:0];
		prod = 17'(off) * 17'(mag);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dq_s[0]  <= prod[NUM_W-1:0];
			rem_s[0] <= '0;
			neg_s[0] <= diff[7];
		end
	end

	// restoring division, four quotient bits per stage
	for (genvar k = 0; k < STAGES; k++) begin : g_div
		logic [NUM_W-1:0] dq_n;
		logic [CFG_W-1:0] rem_n;
		logic [CFG_W:0]   trial;

		always_comb begin
			dq_n  = dq_s[k];
			rem_n = rem_s[k];
			trial = '0;
			for (int i = 0; i < STEPS; i++) begin
				trial = {rem_n, dq_n[NUM_W-1]};
				if (trial >= {1'b0, len}) begin
					trial = trial - {1'b0, len};
					dq_n  = {dq_n[NUM_W-2:0], 1'b1};
				end else begin
					dq_n  = {dq_n[NUM_W-2:0], 1'b0};
				end
				rem_n = trial[CFG_W-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dq_s[k+1]  <= dq_n;
				rem_s[k+1] <= rem_n;
				neg_s[k+1] <= neg_s[k];
			end
		end
	end

	// floor toward minus infinity, offset and clamp
	logic [16:0]       qmag;
	logic signed [18:0] t;

	always_comb begin
		qmag = 17'(dq_s[STAGES]) +
			17'(neg_s[STAGES] && (rem_s[STAGES] != '0));
		t = $signed({12'd0, start}) +
			(neg_s[STAGES] ? -$signed({2'b0, qmag}) : $signed({2'b0, qmag}));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (t < 0) begin
				coord <= '0;
			end else if (t > MAX_C) begin
				coord <= MAX_C[COORD_W-1:0];
			end else begin
				coord <= t[COORD_W-1:0];
			end
		end
	end
endmodule

>>> hdl/trab_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trab_blend
// per channel alpha blend with exact divide by 255, two stages
// ----------------------------------------------------------------------------
module trab_blend (
	input  logic                      clk,
	input  logic                      en,
	input  logic [trab_pkg::PIX_W-1:0] src,
	input  logic [trab_pkg::PIX_W-1:0] dst,
	input  logic                      in_rect,
	output logic [trab_pkg::PIX_W-1:0] pixel,
	output logic                      covered
);
	import trab_pkg::*;

	logic [7:0]       a;
	logic [15:0]      sum [3];
	logic [15:0]      sum_s1 [3];
	logic [PIX_W-1:0] dst_s1;
	logic             in_rect_s1;
	logic [7:0]       chan [3];

	always_comb begin
		a = src[31:24];
		for (int c = 0; c < 3; c++) begin
			sum[c] = 16'(16'(8'd255 - a) * 16'(dst[8*c +: 8])) +
				16'(16'(a) * 16'(src[8*c +: 8]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1     <= sum;
			dst_s1     <= dst;
			in_rect_s1 <= in_rect;
		end
	end

	// floor(x / 255) as (x + 1 + (x >> 8)) >> 8, exact for every x below 65535
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			chan[c] = 8'((17'(sum_s1[c]) + 17'd1 + 17'(sum_s1[c][15:8])) >> 8);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			covered <= in_rect_s1;
			pixel   <= in_rect_s1 ? {dst_s1[31:24], chan[2], chan[1], chan[0]} : dst_s1;
		end
	end
endmodule

>>> hdl/textured_rect_alpha_blit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// textured_rect_alpha_blit_top
// textured rectangle overlay with nearest neighbor fetch and alpha blend
// ----------------------------------------------------------------------------
// Takes one beat per clock on req unless stalled and gives one rsp beat per
// pixel beat, in order; load beats write a texel and give no rsp beat. A beat
// passes ten registers up to and including the output register: one stage
// for the offset and inside test, one for the offset times texture span
// product, four stages of a pipelined divider (four quotient bits each) per
// axis, one for the floor, offset and clamp, one for the texture ram read,
// two for the blend and its divide by 255. Loads write the ram at the same
// stage where pixels read it, so every pixel sees exactly the loads accepted
// before it. The whole pipeline stalls only while the output register holds
// a beat not taken. Configuration may only be written while the pipeline is
// empty.
// ----------------------------------------------------------------------------
module textured_rect_alpha_blit_top #(
	parameter int TEX_W = 64,
	parameter int TEX_H = 64,
	parameter int FB_W  = 1024,
	parameter int FB_H  = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	trab_stream_if.sink                   req,
	trab_stream_if.source                 rsp,
	input  logic                          cfg_we,
	input  logic [trab_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [trab_pkg::CFG_W-1:0]    cfg_wdata
);
	import trab_pkg::*;

	localparam int LAST = 9;   // last side stage before the output register

	// configuration registers
	logic [CFG_W-1:0] rect_x_q, rect_y_q, rect_w_q, rect_h_q;
	logic [6:0]       tex_start_x_q, tex_start_y_q, tex_end_x_q, tex_end_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_x_q      <= '0;
			rect_y_q      <= '0;
			rect_w_q      <= '0;
			rect_h_q      <= '0;
			tex_start_x_q <= '0;
			tex_start_y_q <= '0;
			tex_end_x_q   <= 7'd64;
			tex_end_y_q   <= 7'd64;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_RECT_X:      rect_x_q      <= cfg_wdata;
				REG_RECT_Y:      rect_y_q      <= cfg_wdata;
				REG_RECT_W:      rect_w_q      <= cfg_wdata;
				REG_RECT_H:      rect_h_q      <= cfg_wdata;
				REG_TEX_START_X: tex_start_x_q <= cfg_wdata[6:0];
				REG_TEX_START_Y: tex_start_y_q <= cfg_wdata[6:0];
				REG_TEX_END_X:   tex_end_x_q   <= cfg_wdata[6:0];
				REG_TEX_END_Y:   tex_end_y_q   <= cfg_wdata[6:0];
				default: ;
			endcase
		end
	end

	// global advance: the output register is free or being drained
	logic out_vld_q;
	logic en;

	assign en        = !out_vld_q || rsp.ready;
	assign req.ready = en;
	assign rsp.valid = out_vld_q;

	// offset from the rectangle corner and coverage test
	logic signed [CFG_W:0] offx, offy;
	logic                  in_rect;

	always_comb begin
		offx = $signed({2'b00, req.data.pixel_x}) - $signed({rect_x_q[CFG_W-1], rect_x_q});
		offy = $signed({2'b00, req.data.pixel_y}) - $signed({rect_y_q[CFG_W-1], rect_y_q});
		in_rect = (13'(req.data.pixel_x) < 13'(FB_W)) &&
			(13'(req.data.pixel_y) < 13'(FB_H)) &&
			!offx[CFG_W] && !offy[CFG_W] &&
			(offx[CFG_W-1:0] < rect_w_q) && (offy[CFG_W-1:0] < rect_h_q);
	end

	// side pipeline, stage 1 to LAST
	logic  vld_s [1:LAST];
	side_t side_s [1:LAST];
	logic [COORD_W-1:0] offx_s1, offy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LAST; i++) begin
				vld_s[i] <= 1'b0;
			end
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s[1] <= req.valid;
			for (int i = 2; i <= LAST; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
			out_vld_q <= vld_s[LAST] && side_s[LAST].is_pix;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[1].is_pix  <= (req.data.req_type == REQ_PIXEL);
			side_s[1].in_rect <= in_rect;
			side_s[1].index   <= req.data.texel_index;
			side_s[1].value   <= req.data.texel_value;
			side_s[1].dst     <= req.data.dst_pixel;
			offx_s1           <= offx[COORD_W-1:0];
			offy_s1           <= offy[COORD_W-1:0];
			for (int i = 2; i <= LAST; i++) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

	// texel coordinates, valid at stage 7
	logic [COORD_W-1:0] tx_s7, ty_s7;

	trab_axis #(.SIZE(TEX_W)) u_axis_x (
		.clk   (clk),
		.en    (en),
		.off   (offx_s1),
		.start (tex_start_x_q),
		.stop  (tex_end_x_q),
		.len   (rect_w_q),
		.coord (tx_s7)
	);

	trab_axis #(.SIZE(TEX_H)) u_axis_y (
		.clk   (clk),
		.en    (en),
		.off   (offy_s1),
		.start (tex_start_y_q),
		.stop  (tex_end_y_q),
		.len   (rect_h_q),
		.coord (ty_s7)
	);

	// texture ram: loads write and pixels read at stage 7
	logic [ADDR_W-1:0] rd_addr;
	logic [PIX_W-1:0]  texel_s8;
	logic              ram_we, ram_re;

	assign rd_addr = ADDR_W'(22'(ty_s7) * 22'(TEX_W) + 22'(tx_s7));
	assign ram_we  = en && vld_s[7] && !side_s[7].is_pix;
	assign ram_re  = en;

	trab_ram #(.WIDTH(PIX_W), .DEPTH(MEM_DEPTH)) u_tex_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (side_s[7].index),
		.wdata (side_s[7].value),
		.re    (ram_re),
		.raddr (rd_addr),
		.rdata (texel_s8)
	);

	// blend: products at stage 9, output register after
	trab_blend u_blend (
		.clk     (clk),
		.en      (en),
		.src     (texel_s8),
		.dst     (side_s[8].dst),
		.in_rect (side_s[8].in_rect),
		.pixel   (rsp.data.pixel_out),
		.covered (rsp.data.covered)
	);
endmodule

>>> hdl/trab_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trab_chk
// port level checks of the blitter
// ----------------------------------------------------------------------------
module trab_chk (
	input logic            clk,
	input logic            arst_n,
	input logic            req_ready,
	input logic            rsp_valid,
	input logic            rsp_ready,
	input trab_pkg::rsp_t  rsp_data
);
	import trab_pkg::*;

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("rsp beat dropped or changed while stalled");

	// nothing comes out of reset
	a_rst_idle: assert property (@(posedge clk) !arst_n |-> !rsp_valid)
		else $error("rsp valid during reset");

	// a full stalled output register stops the input side
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !req_ready)
		else $error("req accepted while output stalled");

	// an empty output register never blocks the input side
	a_free_accept: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("req blocked with empty output");
endmodule

bind textured_rect_alpha_blit_top trab_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

>>> dv/textured_rect_alpha_blit_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// textured_rect_alpha_blit_top_test
// self-checking bench for the textured rectangle alpha blitter
// ----------------------------------------------------------------------------
// Loads texels, then streams pixel beats through several rectangle and texture
// window settings. A local model of the blitter predicts every rsp beat; the
// monitor compares them in order. Both channels idle at random.
// ----------------------------------------------------------------------------
module textured_rect_alpha_blit_top_test;
	import trab_pkg::*;

	localparam int TEX_W = 64;
	localparam int TEX_H = 64;
	localparam int FB_W  = 1024;
	localparam int FB_H  = 1024;
	localparam int DRAIN = 40;
	// loaded texture rows and columns: a low band and a high band
	localparam int LO_END   = 16;
	localparam int HI_START = 56;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0] cfg_wdata;

	trab_stream_if #(.T(req_t)) req_ch ();
	trab_stream_if #(.T(rsp_t)) rsp_ch ();

	textured_rect_alpha_blit_top #(
		.TEX_W(TEX_W), .TEX_H(TEX_H), .FB_W(FB_W), .FB_H(FB_H)
	) u_dut (
		.clk(clk), .arst_n(arst_n), .req(req_ch.sink), .rsp(rsp_ch.source),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	// local copy of texture and registers
	logic [31:0] tex_copy [MEM_DEPTH];
	int          win_x, win_y, win_w, win_h;
	int          sx, sy, ex, ey;

	req_t pending_beats [$];
	rsp_t blend_expected [$];
	int   mismatches;
	bit   quiet;        // no idling in this stretch
	bit   hold_send;    // sender paused until everything drained

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4ms;
		$display("textured_rect_alpha_blit_top: mismatch");
		$finish;
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_v);
		$display("error: %s got %h expected %h", what, got, exp_v);
		mismatches++;
	endtask

	// start + floor(off*span/len), clamped to 0..size-1
	function automatic int tex_coord(input int off, input int start, input int stop,
			input int len, input int size);
		int num, q, t;
		num = off * (stop - start);
		if (num >= 0) q = num / len;
		else q = -((-num + len - 1) / len);
		t = start + q;
		if (t < 0) t = 0;
		if (t > size - 1) t = size - 1;
		return t;
	endfunction

	function automatic logic [7:0] mix(input int a, input int s, input int d);
		return 8'(((255 - a) * d + a * s) / 255);
	endfunction

	// row or column that the initial fill loads
	function automatic bit in_band(input int v);
		return (v < LO_END) || (v >= HI_START);
	endfunction

	// texture start and end that only reach loaded rows or columns
	task automatic pick_range(output int s, output int e);
		if ($urandom_range(1) == 0) begin
			s = $urandom_range(LO_END - 1);
			e = $urandom_range(LO_END);
		end else begin
			s = HI_START + $urandom_range(TEX_W - HI_START);
			e = HI_START + $urandom_range(TEX_W - HI_START);
		end
	endtask

	// model one accepted beat
	task automatic predict_beat(input req_t b);
		int ox, oy, tx, ty, addr;
		logic [31:0] src;
		rsp_t r;
		if (b.req_type == REQ_LOAD) begin
			tex_copy[b.texel_index] = b.texel_value;
			return;
		end
		ox = int'(b.pixel_x) - win_x;
		oy = int'(b.pixel_y) - win_y;
		if (b.pixel_x >= FB_W || b.pixel_y >= FB_H || ox < 0 || oy < 0 ||
				ox >= win_w || oy >= win_h) begin
			r.pixel_out = b.dst_pixel;
			r.covered = 1'b0;
		end else begin
			tx = tex_coord(ox, sx, ex, win_w, TEX_W);
			ty = tex_coord(oy, sy, ey, win_h, TEX_H);
			addr = (ty * TEX_W + tx) % MEM_DEPTH;
			src = tex_copy[addr];
			r.pixel_out = {b.dst_pixel[31:24],
				mix(src[31:24], src[23:16], b.dst_pixel[23:16]),
				mix(src[31:24], src[15:8], b.dst_pixel[15:8]),
				mix(src[31:24], src[7:0], b.dst_pixel[7:0])};
			r.covered = 1'b1;
		end
		blend_expected.push_back(r);
	endtask

	// driver: one beat per accepted handshake, random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.data  <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				predict_beat(req_ch.data);
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_beats.size() > 0 && !hold_send &&
						(quiet || $urandom_range(99) >= 24)) begin
					req_ch.data  <= pending_beats.pop_front();
					req_ch.valid <= 1'b1;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: random backpressure, in-order compare
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (blend_expected.size() == 0) begin
					report("unexpected beat", rsp_ch.data.pixel_out, 32'h0);
				end else begin
					rsp_t e;
					e = blend_expected.pop_front();
					if (rsp_ch.data.pixel_out !== e.pixel_out)
						report("pixel_out", rsp_ch.data.pixel_out, e.pixel_out);
					if (rsp_ch.data.covered !== e.covered)
						report("covered", 32'(rsp_ch.data.covered), 32'(e.covered));
				end
			end
			rsp_ch.ready <= quiet || ($urandom_range(99) >= 24);
		end
	end

	// wait until all queued beats are taken and every rsp beat is back
	task automatic drain();
		while (pending_beats.size() > 0 || req_ch.valid || blend_expected.size() > 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= CFG_W'(v);
		@(posedge clk);
		cfg_we    <= 1'b0;
		// model update; writes happen only while idle
		case (idx)
			REG_RECT_X:      win_x = v;
			REG_RECT_Y:      win_y = v;
			REG_RECT_W:      win_w = v;
			REG_RECT_H:      win_h = v;
			REG_TEX_START_X: sx = v;
			REG_TEX_START_Y: sy = v;
			REG_TEX_END_X:   ex = v;
			default:         ey = v;
		endcase
	endtask

	task automatic set_window(input int x, input int y, input int w, input int h,
			input int s_x, input int s_y, input int e_x, input int e_y);
		write_reg(REG_RECT_X, x);
		write_reg(REG_RECT_Y, y);
		write_reg(REG_RECT_W, w);
		write_reg(REG_RECT_H, h);
		write_reg(REG_TEX_START_X, s_x);
		write_reg(REG_TEX_START_Y, s_y);
		write_reg(REG_TEX_END_X, e_x);
		write_reg(REG_TEX_END_Y, e_y);
	endtask

	task automatic push_load(input int idx, input logic [31:0] v);
		req_t b;
		b = '0;
		b.req_type = REQ_LOAD;
		b.texel_index = ADDR_W'(idx);
		b.texel_value = v;
		b.pixel_x = COORD_W'($urandom);
		b.pixel_y = COORD_W'($urandom);
		b.dst_pixel = $urandom;
		pending_beats.push_back(b);
	endtask

	task automatic push_pixel(input int x, input int y, input logic [31:0] d);
		req_t b;
		b.req_type = REQ_PIXEL;
		b.texel_index = ADDR_W'($urandom);
		b.texel_value = $urandom;
		b.pixel_x = COORD_W'(x);
		b.pixel_y = COORD_W'(y);
		b.dst_pixel = d;
		pending_beats.push_back(b);
	endtask

	// random pixel mostly inside/near the rectangle
	task automatic push_near();
		int x, y;
		if ($urandom_range(9) < 7) begin
			x = win_x + $urandom_range(win_w + 3) - 2;
			y = win_y + $urandom_range(win_h + 3) - 2;
			if (x < 0) x = 0;
			if (y < 0) y = 0;
			if (x > 1023) x = 1023;
			if (y > 1023) y = 1023;
		end else begin
			x = $urandom_range(1023);
			y = $urandom_range(1023);
		end
		push_pixel(x, y, $urandom);
	endtask

	initial begin
		mismatches = 0;
		quiet = 1'b0;
		hold_send = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		win_x = 0; win_y = 0; win_w = 0; win_h = 0;
		sx = 0; sy = 0; ex = 64; ey = 64;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the low and high bands of rows and columns; every window
		// below maps only onto these texels
		for (int r = 0; r < TEX_H; r++) begin
			for (int c = 0; c < TEX_W; c++) begin
				if (in_band(r) && in_band(c)) begin
					case ((r + c) % 4)
						0: push_load(r * TEX_W + c, 32'hFFFF_FFFF);
						1: push_load(r * TEX_W + c, 32'h0000_0000);
						default: push_load(r * TEX_W + c, $urandom);
					endcase
				end
			end
		end
		// reset window has zero size: everything passes through
		push_pixel(0, 0, 32'hFFFF_FFFF);
		push_pixel(1023, 1023, 32'h0000_0000);
		drain();

		// directed: low band window at the origin, extremes and edges
		set_window(0, 0, 16, 16, 0, 0, 16, 16);
		push_pixel(0, 0, 32'h0000_0000);
		push_pixel(15, 15, 32'hFFFF_FFFF);
		push_pixel(16, 0, 32'h1234_5678);
		push_pixel(0, 16, 32'h8765_4321);
		push_pixel(1, 0, 32'hFFFF_FFFF);
		push_pixel(1023, 1023, 32'hA5A5_A5A5);
		drain();

		// negative origin, maximum size, reversed texture range with clamp
		set_window(-1024, -1024, 1024, 1024, 64, 64, 56, 56);
		push_pixel(0, 0, 32'h0F0F_0F0F);
		push_pixel(1023, 1023, 32'hF0F0_F0F0);
		push_pixel(0, 1023, 32'h5555_5555);
		drain();

		// largest window, stretched mapping onto the high band
		set_window(0, 0, 1024, 1024, 56, 56, 64, 64);
		push_pixel(1023, 1023, 32'hFFFF_FFFF);
		push_pixel(512, 511, 32'h0000_0000);
		drain();
		set_window(1023, 1023, 1024, 1024, 0, 0, 16, 16);
		push_pixel(1023, 1023, 32'h1357_9BDF);
		drain();

		// random phases with many settings
		for (int ph = 0; ph < 12; ph++) begin
			int n_beats;
			int s_x, s_y, e_x, e_y;
			pick_range(s_x, e_x);
			pick_range(s_y, e_y);
			set_window($urandom_range(1200) - 200, $urandom_range(1200) - 200,
				(ph % 4 == 0) ? $urandom_range(1024) : $urandom_range(80),
				(ph % 4 == 1) ? $urandom_range(1024) : $urandom_range(80),
				s_x, s_y, e_x, e_y);
			quiet = (ph == 5) || (ph == 6);
			n_beats = 42;
			for (int k = 0; k < n_beats; k++) begin
				if ($urandom_range(9) == 0)
					push_load($urandom_range(4095), $urandom);
				else
					push_near();
			end
			if (ph == 3) begin
				// hold the sender until every pixel has returned
				while (pending_beats.size() > 20) @(posedge clk);
				hold_send = 1'b1;
				while (req_ch.valid || blend_expected.size() > 0) @(posedge clk);
				hold_send = 1'b0;
			end
			drain();
			quiet = 1'b0;
		end

		drain();
		if (mismatches == 0)
			$display("textured_rect_alpha_blit_top: match");
		else
			$display("textured_rect_alpha_blit_top: mismatch");
		$finish;
	end

endmodule

>>> filelist.f
hdl/trab_pkg.sv
hdl/trab_stream_if.sv
hdl/trab_ram.sv
hdl/trab_axis.sv
hdl/trab_blend.sv
hdl/textured_rect_alpha_blit_top.sv
hdl/trab_chk.sv
dv/textured_rect_alpha_blit_top_test.sv
